### src/kdkq_pkg.sv
// Shared constants, types and the pin decoder for the keypad debounce key queue.
`default_nettype none

package kdkq_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_KEYS    = 4;
  localparam int CODE_W      = 8;
  localparam int KEY_W       = 3;
  localparam int KEY_IDX_W   = 2;
  localparam int PINS_W      = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [KEY_W-1:0] NO_KEY = 3'd4;

  localparam logic [PINS_W-1:0] PINS_KEY0 = 4'hE;
  localparam logic [PINS_W-1:0] PINS_KEY1 = 4'hD;
  localparam logic [PINS_W-1:0] PINS_KEY2 = 4'hB;
  localparam logic [PINS_W-1:0] PINS_KEY3 = 4'h7;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY3 = 2'd3;

  localparam logic [CODE_W-1:0] CODE_KEY0_RESET = 8'd48;
  localparam logic [CODE_W-1:0] CODE_KEY1_RESET = 8'd49;
  localparam logic [CODE_W-1:0] CODE_KEY2_RESET = 8'd50;
  localparam logic [CODE_W-1:0] CODE_KEY3_RESET = 8'd51;

  // Control broadcast to every queue cell.
  typedef struct packed {
    logic              shift;
    logic              push;
    logic [CODE_W-1:0] code;
  } q_ctrl_t;

  // Press event from the debouncer.
  typedef struct packed {
    logic                 push;
    logic [KEY_IDX_W-1:0] key;
  } press_t;

  function automatic logic [KEY_W-1:0] decode_pins(input logic [PINS_W-1:0] pins);
    logic [KEY_W-1:0] key;
    unique case (pins)
      PINS_KEY0: key = 3'd0;
      PINS_KEY1: key = 3'd1;
      PINS_KEY2: key = 3'd2;
      PINS_KEY3: key = 3'd3;
      default:   key = NO_KEY;
    endcase
    return key;
  endfunction

endpackage

`default_nettype wire

### src/kdkq_cell.sv
// One cell: holds a code and its valid bit, shifts headward on a pop or full push.
`default_nettype none

module kdkq_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire kdkq_pkg::q_ctrl_t       ctrl,
  input  wire logic                    prev_valid,
  input  wire logic                    next_valid,
  input  wire logic [kdkq_pkg::CODE_W-1:0] next_code,
  output logic                         valid,
  output logic [kdkq_pkg::CODE_W-1:0]  code
);
  import kdkq_pkg::*;

  logic fill;

  // The first empty cell, head included, takes a pushed code.
  assign fill = ctrl.push && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (fill) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      code <= next_code;
    end else if (fill) begin
      code <= ctrl.code;
    end
  end

endmodule

`default_nettype wire

### src/kdkq_debounce.sv
// Pin decoder and two-sample debouncer that signals one press per hold.
`default_nettype none

module kdkq_debounce (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         scan_en,
  input  wire logic [kdkq_pkg::PINS_W-1:0]  pins,
  output kdkq_pkg::press_t                  press
);
  import kdkq_pkg::*;

  logic [KEY_W-1:0] last_key;
  logic             queued;
  logic [KEY_W-1:0] key;

  assign key        = decode_pins(pins);
  assign press.push = scan_en && (key != NO_KEY) && (last_key == key) && !queued;
  assign press.key  = key[KEY_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_key <= NO_KEY;
      queued   <= 1'b0;
    end else if (scan_en) begin
      if (key == NO_KEY) begin
        last_key <= NO_KEY;
        queued   <= 1'b0;
      end else if (last_key != key) begin
        // Sliding to another key keeps the queued mark until a release.
        last_key <= key;
      end else if (!queued) begin
        queued <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/keypad_debounce_key_queue.sv
// Top level of the keypad debounce key queue: debouncer, code registers and cell chain.
// A new item is accepted every cycle while the result register is free or being drained
// in the same cycle.
// A read returns its result in the cycle after its transfer, from the head cell.
// Scan items produce no result; their press is queued in the cycle after the transfer.
// Synchronous reset empties the queue, clears the debouncer to no key and restores
// the code registers to the characters '0' to '3'.
`default_nettype none

module keypad_debounce_key_queue (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            opcode,
  input  wire logic [kdkq_pkg::PINS_W-1:0]     pins,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [kdkq_pkg::CODE_W-1:0]          key_code,
  output logic                                 key_valid,
  input  wire logic                            cfg_we,
  input  wire logic [kdkq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kdkq_pkg::CODE_W-1:0]     cfg_data
);
  import kdkq_pkg::*;

  logic                  accept;
  logic                  is_read;
  logic                  pop;
  logic                  full;
  press_t                press;
  q_ctrl_t               ctrl;
  logic [CODE_W-1:0]     code_reg [NUM_KEYS];
  logic                  cell_valid [QUEUE_DEPTH];
  logic [CODE_W-1:0]     cell_code  [QUEUE_DEPTH];

  // The result register parts the two sides: an input transfer is held off only
  // while a finished result waits and the consumer stalls.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_read  = (opcode == OP_READ);

  // Code registers, one per key.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_reg[0] <= CODE_KEY0_RESET;
      code_reg[1] <= CODE_KEY1_RESET;
      code_reg[2] <= CODE_KEY2_RESET;
      code_reg[3] <= CODE_KEY3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CODE_KEY0: code_reg[0] <= cfg_data;
        REG_CODE_KEY1: code_reg[1] <= cfg_data;
        REG_CODE_KEY2: code_reg[2] <= cfg_data;
        REG_CODE_KEY3: code_reg[3] <= cfg_data;
        default:       ;
      endcase
    end
  end

  kdkq_debounce u_debounce (
    .clk     (clk),
    .rst     (rst),
    .scan_en (accept && (opcode == OP_SCAN)),
    .pins    (pins),
    .press   (press)
  );

  // The head cell holds the oldest code. A pop shifts the whole chain one place
  // toward the head. A push into a full chain also shifts, dropping the oldest
  // code, and the new code enters at the tail.
  assign full       = cell_valid[QUEUE_DEPTH-1];
  assign pop        = accept && is_read && cell_valid[0];
  assign ctrl.push  = press.push;
  assign ctrl.code  = code_reg[press.key];
  assign ctrl.shift = pop || (press.push && full);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic              prev_v;
    logic              next_v;
    logic [CODE_W-1:0] next_c;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // On a shift the tail is refilled by any push in that cycle.
      assign next_v = press.push;
      assign next_c = ctrl.code;
    end else begin : g_link
      assign next_v = cell_valid[i+1];
      assign next_c = cell_code[i+1];
    end

    kdkq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_code  (next_c),
      .valid      (cell_valid[i]),
      .code       (cell_code[i])
    );
  end

  // Result register: a read of an empty queue returns code zero with valid clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && is_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      key_valid <= cell_valid[0];
      key_code  <= cell_valid[0] ? cell_code[0] : '0;
    end
  end

endmodule

`default_nettype wire

### src/kdkq_checker.sv
// Port-level checker for the keypad debounce key queue and its bind statement.
`default_nettype none

module kdkq_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            opcode,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [kdkq_pkg::CODE_W-1:0]     key_code,
  input wire logic                            key_valid
);
  import kdkq_pkg::*;

  // A waiting result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(key_code) && $stable(key_valid))
    else $error("stalled result changed");

  // Every accepted read produces a result in the next cycle.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_READ) |=> out_valid)
    else $error("read transfer without result");

  // An empty read returns code zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_code == '0)
    else $error("empty read returned nonzero code");

  // The input side is held off only while a result waits on a stalled consumer.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind keypad_debounce_key_queue kdkq_checker u_kdkq_checker (.*);

`default_nettype wire
